// ===== sv/sdw_pkg.sv =====
// Package for the square-to-disc row warp: sizes, the sequencer states and
// the pixel packing helper. Depends on nothing.
`default_nettype none
package sdw_pkg;

  localparam int MAX_HALF_WIDTH = 512;
  localparam int FRACTION_BITS  = 8;
  localparam int CHANNELS       = 3;

  localparam int N_W       = $clog2(MAX_HALF_WIDTH + 1);
  localparam int COL_W     = $clog2(2 * MAX_HALF_WIDTH);
  localparam int ROW_SLOTS = 2 * MAX_HALF_WIDTH;
  localparam int ADDR_W    = COL_W + 1;
  localparam int STORE_DEPTH = 2 * ROW_SLOTS;
  localparam int PIX_W     = 24;
  localparam int STEP_W    = 20;
  localparam int NUM_W     = N_W + FRACTION_BITS;
  localparam int P_W       = STEP_W + COL_W + 1;
  localparam int V_W       = 2 * N_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int SQ_CNT_W  = $clog2(N_W + 1);
  localparam int HW_W      = 10;
  localparam int PADDR_W   = 3;

  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(256);
  localparam logic            REG_HALF_WIDTH   = 1'b0;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POS  = 8'b0000_0010,
    S_RD0  = 8'b0000_0100,
    S_RD1  = 8'b0000_1000,
    S_EMIT = 8'b0001_0000,
    S_SQ   = 8'b0010_0000,
    S_SQRT = 8'b0100_0000,
    S_DIV  = 8'b1000_0000
  } state_e;

  // Packs the channels into one store word; channels beyond CHANNELS are zero.
  function automatic logic [PIX_W-1:0] pack_pix(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [PIX_W-1:0] word;
    word = '0;
    word[7:0] = r;
    if (CHANNELS > 1) word[15:8] = g;
    if (CHANNELS > 2) word[23:16] = b;
    return word;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sdw_pix_in_if.sv =====
// Input pixel channel of the row warp: valid, ready, the pixel payload and a flush flag.
// Depends on nothing.
`default_nettype none
interface sdw_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       flush;
  modport source (output valid, red_in, green_in, blue_in, flush, input ready);
  modport sink (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface
`default_nettype wire

// ===== sv/sdw_pix_out_if.sv =====
// Output pixel channel of the row warp: valid, ready and the warped pixel with its row,
// column and row-end flag. Depends on nothing.
`default_nettype none
interface sdw_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [9:0] out_row;
  logic [9:0] out_column;
  logic       row_end;
  modport source (output valid, red_out, green_out, blue_out, out_row, out_column, row_end,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, out_row, out_column, row_end,
                output ready);
endinterface
`default_nettype wire

// ===== sv/sdw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. Depends on nothing.
`default_nettype none
module sdw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/square_to_disc_row_warp.sv =====
// Square-to-disc row warp. An item that emits nothing returns to idle; a
// black pixel passes through S_EMIT and an interpolated one through S_POS,
// S_RD0, S_RD1 and S_EMIT, which waits while a stalled sink holds the output
// register; the two store reads share the single RAM read port. The last pixel
// of a row adds the row's square root and step division, or only the square
// root for an empty chord. Reset clears all control state; the line store
// holds no reset value and is only read where written.
`default_nettype none
module square_to_disc_row_warp
  import sdw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sdw_pix_in_if.sink              pix_i,
  sdw_pix_out_if.source           pix_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  // Configuration register and row bookkeeping.
  logic [HW_W-1:0]   half_width_q;
  logic [COL_W-1:0]  load_col_q;
  logic [COL_W-1:0]  load_row_q;
  logic              bank_q;
  logic              row_ready_q;
  logic [N_W-1:0]    chord_q;
  logic [STEP_W-1:0] step_q;
  state_e            state_q;

  // Per-item working registers.
  logic [COL_W-1:0]  e_col_q;
  logic [COL_W-1:0]  e_row_q;
  logic              e_last_q;
  logic              e_inside_q;
  logic              e_right_q;
  logic [COL_W-1:0]  e_j_q;
  logic              rd_bank_q;
  logic              params_q;
  logic [COL_W-1:0]  r_q;
  logic [P_W-1:0]    p_q;
  logic [PIX_W-1:0]  a_q;

  // Square root and division unit.
  logic [V_W-1:0]       v_q;
  logic [V_W-1:0]       root_q;
  logic [V_W-1:0]       bit_q;
  logic [SQ_CNT_W-1:0]  sq_cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [N_W:0]         rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  red_q, green_q, blue_q;
  logic [9:0]  orow_q, ocol_q;
  logic        oend_q;

  // Effective N, saturated to [1, MAX_HALF_WIDTH].
  logic [N_W-1:0]   n;
  logic [COL_W:0]   w_ext;
  logic [COL_W-1:0] w_m1;
  always_comb begin
    if (half_width_q == '0) begin
      n = N_W'(1);
    end else if (half_width_q > HW_W'(MAX_HALF_WIDTH)) begin
      n = N_W'(MAX_HALF_WIDTH);
    end else begin
      n = N_W'(half_width_q);
    end
    w_ext = {(COL_W + 1 - N_W)'(0), n} << 1;
    w_m1  = COL_W'(w_ext - (COL_W + 1)'(1));
  end

  // Current column and row, with the emission geometry of the buffered row.
  logic [COL_W-1:0] col;
  logic             col_last;
  logic [COL_W-1:0] row_out;
  logic [COL_W-1:0] r_cur;
  logic             in_chord;
  logic             right_half;
  logic [COL_W-1:0] j_c;
  logic [COL_W:0]   col_ext, n_ext, m_ext;
  always_comb begin
    col      = (load_col_q > w_m1) ? w_m1 : load_col_q;
    col_last = (col == w_m1);
    row_out  = (load_row_q == '0) ? w_m1 : load_row_q - COL_W'(1);
    r_cur    = (load_row_q > w_m1) ? w_m1 : load_row_q;
    col_ext  = {1'b0, col};
    n_ext    = (COL_W + 1)'(n);
    m_ext    = (COL_W + 1)'(chord_q);
    in_chord = (chord_q != '0) && (col_ext + m_ext >= n_ext) && (col_ext < n_ext + m_ext);
    right_half = (col_ext >= n_ext);
    if (right_half) begin
      j_c = COL_W'(col_ext - n_ext);
    end else begin
      j_c = COL_W'(col_ext - (n_ext - m_ext));
    end
  end

  logic accept;
  logic is_flush;
  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign is_flush    = pix_i.flush;

  // Source index pair, clamped to the row, and the fraction.
  logic [P_W-FRACTION_BITS-1:0] y_full;
  logic [COL_W-1:0]             y0, y1;
  logic [FRACTION_BITS-1:0]     frac;
  always_comb begin
    y_full = p_q[P_W-1:FRACTION_BITS];
    frac   = p_q[FRACTION_BITS-1:0];
    y0 = (y_full > (P_W - FRACTION_BITS)'(w_m1)) ? w_m1 : COL_W'(y_full);
    y1 = (y0 == w_m1) ? w_m1 : y0 + COL_W'(1);
  end

  // Line store: the loading bank is written on every pixel beat, the other
  // bank is read for the emitted pixel.
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;
  assign raddr = {rd_bank_q, (state_q == S_RD0) ? y0 : y1};

  sdw_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept && !is_flush),
    .waddr_i({bank_q, col}),
    .wdata_i(pack_pix(pix_i.red_in, pix_i.green_in, pix_i.blue_in)),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Linear interpolation between the two source pixels.
  logic [7:0] mix [3];
  always_comb begin
    logic [FRACTION_BITS:0] wgt;
    wgt = (FRACTION_BITS + 1)'(1 << FRACTION_BITS) - (FRACTION_BITS + 1)'(frac);
    for (int k = 0; k < 3; k++) begin
      logic [FRACTION_BITS+8:0] acc;
      acc = (FRACTION_BITS + 9)'(wgt) * (FRACTION_BITS + 9)'(a_q[8*k +: 8])
          + (FRACTION_BITS + 9)'(frac) * (FRACTION_BITS + 9)'(rdata[8*k +: 8])
          + (FRACTION_BITS + 9)'(1 << (FRACTION_BITS - 1));
      mix[k] = e_inside_q ? acc[FRACTION_BITS +: 8] : 8'd0;
    end
  end

  logic out_free;
  logic emit_fire;
  assign out_free  = !out_valid_q || pix_o.ready;
  assign emit_fire = (state_q == S_EMIT) && out_free;

  // Distance of the finished row from the center, mirrored for the lower half.
  logic [N_W-1:0] row_dist;
  always_comb begin
    if ((COL_W + 1)'(r_q) < n_ext) begin
      row_dist = N_W'(n_ext - (COL_W + 1)'(r_q) - (COL_W + 1)'(1));
    end else begin
      row_dist = N_W'((COL_W + 1)'(r_q) - n_ext);
    end
    if (row_dist > n) row_dist = n;
  end

  // One bit of the square root and one bit of the division per cycle.
  logic [V_W-1:0] sq_try;
  logic [N_W:0]   rem_sh;
  assign sq_try = root_q + bit_q;
  assign rem_sh = {rem_q[N_W-1:0], num_q[NUM_W-1]};

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_HALF_WIDTH);
  assign pready = 1'b1;
  assign prdata = {(32 - HW_W)'(0), half_width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RESET;
      load_col_q   <= '0;
      load_row_q   <= '0;
      bank_q       <= 1'b0;
      row_ready_q  <= 1'b0;
      chord_q      <= '0;
      step_q       <= '0;
      state_q      <= S_IDLE;
      params_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            e_col_q    <= col;
            e_row_q    <= row_out;
            e_last_q   <= col_last;
            e_inside_q <= in_chord;
            e_right_q  <= right_half;
            e_j_q      <= j_c;
            rd_bank_q  <= ~bank_q;
            r_q        <= r_cur;
            if (is_flush) begin
              if (row_ready_q) begin
                state_q  <= in_chord ? S_POS : S_EMIT;
                params_q <= 1'b0;
                if (col_last) begin
                  row_ready_q <= 1'b0;
                  load_col_q  <= '0;
                end else begin
                  load_col_q <= col + COL_W'(1);
                end
              end
            end else begin
              params_q <= col_last;
              if (row_ready_q) begin
                state_q <= in_chord ? S_POS : S_EMIT;
              end else if (col_last) begin
                state_q <= S_SQ;
              end
              if (col_last) begin
                bank_q      <= ~bank_q;
                row_ready_q <= 1'b1;
                load_col_q  <= '0;
                load_row_q  <= (r_cur == w_m1) ? '0 : r_cur + COL_W'(1);
              end else begin
                load_col_q <= col + COL_W'(1);
              end
            end
          end
        end
        S_POS: begin
          p_q <= P_W'(step_q) * P_W'(e_j_q)
               + (e_right_q ? P_W'({n, {FRACTION_BITS{1'b0}}}) : P_W'(0));
          state_q <= S_RD0;
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          a_q     <= rdata;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            red_q   <= mix[0];
            green_q <= mix[1];
            blue_q  <= mix[2];
            orow_q  <= 10'(e_row_q);
            ocol_q  <= 10'(e_col_q);
            oend_q  <= e_last_q;
            state_q <= params_q ? S_SQ : S_IDLE;
          end
        end
        S_SQ: begin
          v_q      <= V_W'(n) * V_W'(n) - V_W'(row_dist) * V_W'(row_dist);
          root_q   <= '0;
          bit_q    <= V_W'(1) << (V_W - 2);
          sq_cnt_q <= '0;
          state_q  <= S_SQRT;
        end
        S_SQRT: begin
          if (v_q >= sq_try) begin
            v_q    <= v_q - sq_try;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q    <= bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
          if (sq_cnt_q == SQ_CNT_W'(N_W - 1)) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // On entry this state latches the root, then seeds the divider.
          if (params_q) begin
            chord_q   <= N_W'(root_q);
            params_q  <= 1'b0;
            div_cnt_q <= '0;
          end else if (div_cnt_q == '0) begin
            if (chord_q == '0) begin
              step_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              num_q     <= NUM_W'({n, {FRACTION_BITS{1'b0}}}) + NUM_W'(chord_q >> 1);
              rem_q     <= '0;
              div_cnt_q <= DIV_CNT_W'(1);
            end
          end else begin
            num_q <= {num_q[NUM_W-2:0], (rem_sh >= (N_W + 1)'(chord_q))};
            rem_q <= (rem_sh >= (N_W + 1)'(chord_q)) ? rem_sh - (N_W + 1)'(chord_q)
                                                    : rem_sh;
            if (div_cnt_q == DIV_CNT_W'(NUM_W)) begin
              step_q    <= STEP_W'({num_q[NUM_W-2:0],
                                     (rem_sh >= (N_W + 1)'(chord_q))});
              div_cnt_q <= '0;
              state_q   <= S_IDLE;
            end else begin
              div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (state_q == S_SQ) begin
        params_q  <= 1'b1;
        div_cnt_q <= '0;
      end
      if (cfg_we) begin
        half_width_q <= pwdata[HW_W-1:0];
        load_col_q   <= '0;
        load_row_q   <= '0;
        row_ready_q  <= 1'b0;
      end
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.red_out    = red_q;
  assign pix_o.green_out  = green_q;
  assign pix_o.blue_out   = blue_q;
  assign pix_o.out_row    = orow_q;
  assign pix_o.out_column = ocol_q;
  assign pix_o.row_end    = oend_q;

endmodule
`default_nettype wire
